// File: rtl/sac_pkg.sv
// ============================================================================
// sac_pkg - shared constants for the set-associative LRU cache lookup
// Field widths of the reference and result channels, and the digit size of
// the set index reduction.
// ============================================================================
package sac_pkg;

    localparam int REF_W     = 32;  // block reference, also the stored tag
    localparam int WAY_OUT_W = 2;   // way number on the result channel
    localparam int MISS_W    = 32;  // saturating miss total
    localparam int DIGIT_W   = 4;   // reference bits per digit in the set residue lookup

endpackage

// File: rtl/sac_row_ram.sv
// ============================================================================
// sac_row_ram - one set per row, single write port, registered read port
// Read data appears in the cycle after the read enable and holds until the
// next read.
// ============================================================================
module sac_row_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sac_set_mod.sv
// ============================================================================
// sac_set_mod - set index = reference modulo SETS
// Power-of-two set counts take a mask, done in the cycle after start. Other
// counts look up the residue of each reference digit in a constant table,
// sum the residues, then reduce the sum with parallel compares; residues,
// sum and reduced index are each registered before done rises.
// ============================================================================
module sac_set_mod #(
    parameter int SETS = 16,
    parameter int SW   = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [sac_pkg::REF_W-1:0] ref_in,
    output logic                     done,
    output logic [SW-1:0]            set_idx
);
    import sac_pkg::*;

    localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

    // residue of one digit value at its position: (val << DIGIT_W*pos) mod SETS
    function automatic logic [SW-1:0] digit_residue(input int pos, input int val);
        logic [63:0] wide;
        wide = 64'(val) << (DIGIT_W * pos);
        return SW'(wide % 64'(SETS));
    endfunction

    generate
        if (POW2) begin : g_mask
            logic          done_reg;
            logic [SW-1:0] set_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    set_reg <= ref_in[SW-1:0] & SW'(SETS - 1);
                end
            end

            assign done    = done_reg;
            assign set_idx = set_reg;
        end else begin : g_fold
            localparam int NDIG  = REF_W / DIGIT_W;
            localparam int DV    = 1 << DIGIT_W;
            localparam int SUM_W = SW + $clog2(NDIG);

            logic                    res_vld_reg;
            logic                    sum_vld_reg;
            logic                    done_reg;
            logic [NDIG-1:0][SW-1:0] res_reg;
            logic [NDIG-1:0][SW-1:0] res_next;
            logic [SUM_W-1:0]        sum_reg;
            logic [SUM_W-1:0]        sum_next;
            logic [SUM_W-1:0]        red;
            logic [SW-1:0]           set_reg;

            // per-digit residues from constant tables
            always_comb begin
                res_next = '0;
                for (int i = 0; i < NDIG; i++) begin
                    for (int d = 0; d < DV; d++) begin
                        if (ref_in[DIGIT_W*i +: DIGIT_W] == DIGIT_W'(d)) begin
                            res_next[i] = digit_residue(i, d);
                        end
                    end
                end
            end

            always_comb begin
                sum_next = '0;
                for (int i = 0; i < NDIG; i++) begin
                    sum_next = sum_next + SUM_W'(res_reg[i]);
                end
            end

            // sum < NDIG*SETS: subtract the largest multiple of SETS that fits
            always_comb begin
                red = sum_reg;
                for (int k = 1; k < NDIG; k++) begin
                    if (sum_reg >= SUM_W'(k * SETS)) begin
                        red = sum_reg - SUM_W'(k * SETS);
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    res_vld_reg <= 1'b0;
                    sum_vld_reg <= 1'b0;
                    done_reg    <= 1'b0;
                end else begin
                    res_vld_reg <= start;
                    sum_vld_reg <= res_vld_reg;
                    done_reg    <= sum_vld_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    res_reg <= res_next;
                end
                if (res_vld_reg) begin
                    sum_reg <= sum_next;
                end
                if (sum_vld_reg) begin
                    set_reg <= red[SW-1:0];
                end
            end

            assign done    = done_reg;
            assign set_idx = set_reg;
        end
    endgenerate

endmodule

// File: rtl/sac_pick.sv
// ============================================================================
// sac_pick - way selection within one set
// Finds the matching way, else the first empty way, else the least recently
// used way (largest rank, lowest way on a tie), and that way's old rank.
// ============================================================================
module sac_pick #(
    parameter int WAYS = 4,
    parameter int WW   = 2,
    parameter int RKW  = 2,
    parameter int ORW  = 3
) (
    input  logic [sac_pkg::REF_W-1:0]            ref_in,
    input  logic [WAYS-1:0]                      vld,
    input  logic [WAYS-1:0][RKW-1:0]             rank,
    input  logic [WAYS-1:0][sac_pkg::REF_W-1:0]  tag,
    output logic                                 found,
    output logic [WW-1:0]                        chosen,
    output logic [ORW-1:0]                       old_rank
);
    import sac_pkg::*;

    logic [WAYS-1:0] hit_vec;
    logic [WAYS-1:0] vic_vec;
    logic [WAYS-1:0] sel_vec;

    // each way checks itself against all others, no dependent chain
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = vld[w] && (tag[w] == ref_in);
            vic_vec[w] = vld[w];
            for (int j = 0; j < WAYS; j++) begin
                if (j != w && vld[j] &&
                    ((rank[j] > rank[w]) || ((rank[j] == rank[w]) && (j < w)))) begin
                    vic_vec[w] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        found = |hit_vec;
        if (found) begin
            sel_vec = hit_vec;
        end else if (|(~vld)) begin
            sel_vec = ~vld;
        end else begin
            sel_vec = vic_vec;
        end
        // lowest set bit wins
        chosen = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (sel_vec[w]) begin
                chosen = WW'(w);
            end
        end
        old_rank = vld[chosen] ? ORW'(rank[chosen]) : ORW'(WAYS);
    end

endmodule

// File: rtl/set_assoc_lru_cache_lookup_top.sv
// ============================================================================
// set_assoc_lru_cache_lookup_top - set-associative cache lookup, LRU replace
// Each reference is looked up in set (reference mod SETS); the result gives
// hit or miss, the way now holding the reference, and a saturating miss total.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_reference[31:0]
//   m_       out        m_valid/m_ready    m_hit, m_way[1:0], m_miss_total[31:0]
//
// One reference at a time: accept, set reduction, row read, way pick, write
// back. When SETS is not a power of two, the set reduction also sums and
// reduces digit residues in the modulo unit.
// After reset a clearing pass writes every row once, with s_ready low.
// A new reference is taken while a result waits on m_; the write-back stage
// holds until the output register is free.
// ============================================================================
module set_assoc_lru_cache_lookup_top #(
    parameter int SETS = 16,
    parameter int WAYS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sac_pkg::REF_W-1:0]     s_reference,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [sac_pkg::WAY_OUT_W-1:0] m_way,
    output logic [sac_pkg::MISS_W-1:0]    m_miss_total
);
    import sac_pkg::*;

    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RKW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ORW   = $clog2(WAYS + 1);
    localparam int ROW_W = WAYS * (1 + RKW + REF_W);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_PICK,
        ST_WRITE
    } state_t;

    state_t           state_reg;
    logic [SW-1:0]    clr_cnt_reg;
    logic [REF_W-1:0] ref_reg;
    logic             found_reg;
    logic [WW-1:0]    chosen_reg;
    logic [ORW-1:0]   old_rank_reg;
    logic [MISS_W-1:0] miss_reg;
    logic [MISS_W-1:0] miss_next;
    logic             m_valid_reg;
    logic             m_hit_reg;
    logic [WAY_OUT_W-1:0] m_way_reg;

    // set reduction
    logic          mod_start;
    logic          mod_done;
    logic [SW-1:0] set_idx;

    // row memory ports
    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [ROW_W-1:0] ram_rdata;

    // row fields as read and as written back
    logic [WAYS-1:0]             rd_vld;
    logic [WAYS-1:0][RKW-1:0]    rd_rank;
    logic [WAYS-1:0][REF_W-1:0]  rd_tag;
    logic [WAYS-1:0]             wr_vld;
    logic [WAYS-1:0][RKW-1:0]    wr_rank;
    logic [WAYS-1:0][REF_W-1:0]  wr_tag;

    // way pick
    logic           pk_found;
    logic [WW-1:0]  pk_chosen;
    logic [ORW-1:0] pk_old_rank;

    logic out_free;
    logic commit;
    logic clearing;

    assign s_ready   = (state_reg == ST_IDLE);
    assign mod_start = s_valid && s_ready;

    sac_set_mod #(
        .SETS (SETS),
        .SW   (SW)
    ) u_set_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .ref_in  (s_reference),
        .done    (mod_done),
        .set_idx (set_idx)
    );

    assign {rd_vld, rd_rank, rd_tag} = ram_rdata;

    sac_pick #(
        .WAYS (WAYS),
        .WW   (WW),
        .RKW  (RKW),
        .ORW  (ORW)
    ) u_pick (
        .ref_in   (ref_reg),
        .vld      (rd_vld),
        .rank     (rd_rank),
        .tag      (rd_tag),
        .found    (pk_found),
        .chosen   (pk_chosen),
        .old_rank (pk_old_rank)
    );

    // New row: chosen way becomes most recent, ways younger than its old
    // rank age by one, the rest keep their rank.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            wr_vld[w]  = rd_vld[w];
            wr_rank[w] = rd_rank[w];
            wr_tag[w]  = rd_tag[w];
            if (WW'(w) == chosen_reg) begin
                wr_vld[w]  = 1'b1;
                wr_rank[w] = '0;
                wr_tag[w]  = ref_reg;
            end else if (rd_vld[w] && (ORW'(rd_rank[w]) < old_rank_reg)) begin
                wr_rank[w] = rd_rank[w] + 1'b1;
            end
        end
    end

    // saturating miss counter
    assign miss_next = (!found_reg && (miss_reg != '1)) ? miss_reg + 1'b1 : miss_reg;

    // write back only when the output register can take the result
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_WRITE) && out_free;
    assign clearing = (state_reg == ST_CLEAR);

    assign ram_we    = clearing || commit;
    assign ram_waddr = clearing ? clr_cnt_reg : set_idx;
    assign ram_wdata = clearing ? '0 : {wr_vld, wr_rank, wr_tag};
    assign ram_re    = (state_reg == ST_READ);

    sac_row_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (SW)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (set_idx),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            miss_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // drop the result once the transfer completes
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == SW'(SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (mod_start) begin
                        ref_reg   <= s_reference;
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (mod_done) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_PICK;
                end
                ST_PICK: begin
                    found_reg    <= pk_found;
                    chosen_reg   <= pk_chosen;
                    old_rank_reg <= pk_old_rank;
                    state_reg    <= ST_WRITE;
                end
                ST_WRITE: begin
                    // hold until the previous result has gone out
                    if (out_free) begin
                        miss_reg    <= miss_next;
                        m_valid_reg <= 1'b1;
                        m_hit_reg   <= found_reg;
                        m_way_reg   <= WAY_OUT_W'(chosen_reg);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_way        = m_way_reg;
    assign m_miss_total = miss_reg;

endmodule

// File: tb/sv/tb.sv
// ============================================================================
// tb - regression for set_assoc_lru_cache_lookup_top
// Streams block references through the lookup and checks every result against
// a cycle-free model of a 16-set, 4-way cache with LRU replacement: hit flag,
// way now holding the reference, and the saturating miss total. Directed
// corner cases come first, then random traffic under several idle and stall
// mixes with a full drain between phases.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sac_pkg::*;

    localparam int SETS        = 16;
    localparam int WAYS        = 4;
    localparam int SET_W       = $clog2(SETS);
    localparam int TAG_W       = REF_W - SET_W;
    localparam int POOL_TAGS   = 6;     // more tags than ways per set: hits and evictions
    localparam int PHASE_ITEMS = 370;
    localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up
    localparam int TAIL_CYCLES = 50;    // well past the lookup latency

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [MISS_W-1:0]    miss_total;
    } lookup_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block I/O; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [REF_W-1:0]     s_reference = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_hit;
    logic [WAY_OUT_W-1:0] m_way;
    logic [MISS_W-1:0]    m_miss_total;

    always #5 aclk = ~aclk;

    set_assoc_lru_cache_lookup_top #(
        .SETS(SETS),
        .WAYS(WAYS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_reference (s_reference),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_way       (m_way),
        .m_miss_total(m_miss_total)
    );

    // ------------------------------------------------------------------
    // Shared bench state.
    // ------------------------------------------------------------------
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    lookup_result_t   pending_lookups[$];   // predicted results, oldest first
    logic [TAG_W-1:0] tag_pool[POOL_TAGS];

    // Cache shadow: tags are only read where the line is in use.
    logic [REF_W-1:0]  line_tag  [SETS][WAYS];
    bit                line_used [SETS][WAYS];
    int                line_rank [SETS][WAYS];  // 0 = most recently used
    logic [MISS_W-1:0] misses_so_far = '0;

    // ------------------------------------------------------------------
    // Predict one lookup and update the shadow cache.
    // ------------------------------------------------------------------
    function automatic lookup_result_t predict_lookup(input logic [REF_W-1:0] addr);
        int unsigned    set_idx;
        int             chosen;
        int             victim;
        int             empty_way;
        int             old_rank;
        bit             found;
        bit             empty_found;
        bit             victim_set;
        lookup_result_t res;
        set_idx     = addr % SETS;
        chosen      = 0;
        victim      = 0;
        empty_way   = 0;
        found       = 1'b0;
        empty_found = 1'b0;
        victim_set  = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (line_used[set_idx][w]) begin
                // lowest matching way wins; victim is the oldest, ties to the low way
                if (!found && line_tag[set_idx][w] == addr) begin
                    found  = 1'b1;
                    chosen = w;
                end
                if (!victim_set || line_rank[set_idx][w] > line_rank[set_idx][victim]) begin
                    victim     = w;
                    victim_set = 1'b1;
                end
            end else if (!empty_found) begin
                empty_found = 1'b1;
                empty_way   = w;
            end
        end
        if (!found) begin
            if (misses_so_far != '1)
                misses_so_far++;
            chosen = empty_found ? empty_way : victim;
        end
        old_rank = line_used[set_idx][chosen] ? line_rank[set_idx][chosen] : WAYS;
        // age every line that was more recent than the chosen one
        for (int w = 0; w < WAYS; w++) begin
            if (w != chosen && line_used[set_idx][w] && line_rank[set_idx][w] < old_rank)
                line_rank[set_idx][w]++;
        end
        line_tag[set_idx][chosen]  = addr;
        line_used[set_idx][chosen] = 1'b1;
        line_rank[set_idx][chosen] = 0;
        res.hit        = found;
        res.way        = WAY_OUT_W'(chosen);
        res.miss_total = misses_so_far;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Randomize the receiver: drop m_ready in sink_stall_pct of cycles.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input transfer, check each result transfer,
    // and end the run once quiet_cycles, the stretch with nothing moving, reaches QUIET_LIMIT.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn) begin
            // push before pop: a result never belongs to the reference taken at this edge
            if (s_valid && s_ready)
                pending_lookups.push_back(predict_lookup(s_reference));
            if (m_valid && m_ready) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch($sformatf("result with no lookup pending: hit=%0b way=%0d",
                                              m_hit, m_way));
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_hit !== want.hit)
                        report_mismatch($sformatf("hit: got %0b, want %0b", m_hit, want.hit));
                    if (m_way !== want.way)
                        report_mismatch($sformatf("way: got %0d, want %0d", m_way, want.way));
                    if (m_miss_total !== want.miss_total)
                        report_mismatch($sformatf("miss_total: got %0d, want %0d",
                                                  m_miss_total, want.miss_total));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("set_assoc_lru_cache_lookup_top regression: fail");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Send one reference. Call it right after the clock rises; return at the edge
    // of the transfer with s_valid still high, so the next call either keeps
    // it high with new data or drops it for an idle gap (one update per step).
    // ------------------------------------------------------------------
    task automatic send_reference(input logic [REF_W-1:0] addr);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_reference <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_lookups.size() != 0);
    endtask

    // Mostly tags from a small per-phase pool so sets fill, hit and evict;
    // the rest all-zero, all-one or fully random tags.
    function automatic logic [REF_W-1:0] random_reference();
        int               pick;
        logic [TAG_W-1:0] tag;
        pick = $urandom_range(99);
        if (pick < 75)
            tag = tag_pool[$urandom_range(POOL_TAGS-1)];
        else if (pick < 80)
            tag = pick[0] ? '0 : '1;
        else
            tag = TAG_W'($urandom);
        return {tag, SET_W'($urandom_range(SETS-1))};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Address extremes: all zeros and all ones are ordinary references.
    task automatic test_corner_references();
        send_reference(32'h0000_0000);  // cold miss, way 0
        send_reference(32'h0000_0000);  // hit
        send_reference(32'hFFFF_FFFF);  // set 15, cold miss
        send_reference(32'hFFFF_FFFF);  // hit
        send_reference(32'h7FFF_FFFF);  // set 15, next empty way
        send_reference(32'h8000_0000);  // set 0, next empty way
        send_reference(32'hAAAA_AAA0);  // set 0 fills up
        send_reference(32'h5555_5550);
        send_reference(32'h0000_0010);  // set 0 full: evict the least recent
        hold_until_drained();
    endtask

    // Fill one set, reorder recency with hits, then force evictions.
    task automatic test_lru_replacement();
        send_reference({28'h000_000A, 4'h5});
        send_reference({28'h000_000B, 4'h5});
        send_reference({28'h000_000C, 4'h5});
        send_reference({28'h000_000D, 4'h5});  // set 5 now full
        send_reference({28'h000_000B, 4'h5});  // hit in a middle way
        send_reference({28'h000_000A, 4'h5});  // hit on the oldest line
        send_reference({28'h000_000E, 4'h5});  // evicts C
        send_reference({28'h000_000C, 4'h5});  // evicts D
        send_reference({28'h000_000E, 4'h5});  // hit on a replaced way
        // thrash: five tags cycling through four ways miss every time
        for (int i = 0; i < 10; i++)
            send_reference({28'(32'h100 + i % 5), 4'h9});
        hold_until_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        foreach (tag_pool[i])
            tag_pool[i] = TAG_W'($urandom);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause mid-phase until the pipeline is empty, then resume
            if (n == PHASE_ITEMS / 2)
                hold_until_drained();
            send_reference(random_reference());
        end
        hold_until_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed tests, random phases, tail, verdict.
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_corner_references();
        test_lru_replacement();
        test_random_traffic(0, 0);
        test_random_traffic(55, 0);
        test_random_traffic(0, 55);
        test_random_traffic(33, 33);

        // let any stray result surface before the verdict
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("set_assoc_lru_cache_lookup_top regression: pass");
        else
            $display("set_assoc_lru_cache_lookup_top regression: fail");
        $finish;
    end

endmodule
